// ===== rtl/mbe_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and arithmetic helpers for the escape-time block
package mbe_pkg;

	localparam int COORD_W   = 32;
	localparam int ITER_W    = 16;
	localparam int FRAC_BITS = 24;
	localparam int ACC_W     = 48;
	localparam int HALF_W    = ACC_W - FRAC_BITS;
	localparam int PP_W      = 2 * HALF_W;
	localparam int SUM_W     = ACC_W + 2;
	localparam int OUT_BYTES = (ITER_W + 7) / 8;

	localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] THRESHOLD = ACC_W'(1000) <<< FRAC_BITS;

	// operand pair chosen for the shared multiplier
	typedef logic [1:0] mbe_sel_t;
	localparam mbe_sel_t SEL_AA = 2'd0;
	localparam mbe_sel_t SEL_BB = 2'd1;
	localparam mbe_sel_t SEL_AB = 2'd2;

	typedef struct packed {
		logic     load;
		logic     issue;
		mbe_sel_t sel;
		logic     update;
	} mbe_cmd_t;

	typedef struct packed {
		logic above_thr;
	} mbe_sts_t;

	// saturate a widened sum back to the accumulator range
	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
		logic [2:0] top;
		top = x[SUM_W-1:ACC_W-1];
		if (top == 3'b000 || top == 3'b111)
			return x[ACC_W-1:0];
		else if (x[SUM_W-1])
			return ACC_MIN;
		else
			return ACC_MAX;
	endfunction

	// magnitude of an accumulator value, exact for the most negative code
	function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] x);
		if (x[ACC_W-1])
			return ACC_W'(-x);
		else
			return x;
	endfunction

endpackage

// ===== rtl/mbe_datapath.sv =====
`timescale 1ns / 1ps
// iterate registers, shared split multiplier and update adders
module mbe_datapath
	import mbe_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [COORD_W-1:0] point_re,
	input  logic signed [COORD_W-1:0] point_im,
	input  mbe_cmd_t                  cmd,
	output mbe_sts_t                  sts
);

	logic signed [COORD_W-1:0] re_q, im_q;
	logic signed [ACC_W-1:0]   a_q, b_q;
	logic signed [ACC_W-1:0]   aa_q, bb_q, ab_q;

	// multiplier stage 1: partial products of the magnitudes
	logic [PP_W-1:0] hh_s1, hl_s1, lh_s1, ll_s1;
	logic            neg_s1;
	logic            vld_s1;
	mbe_sel_t        sel_s1;

	logic signed [ACC_W-1:0] mx, my;
	logic [ACC_W-1:0]        ux, uy;

	always_comb begin
		case (cmd.sel)
			SEL_AA: begin
				mx = a_q;
				my = a_q;
			end
			SEL_BB: begin
				mx = b_q;
				my = b_q;
			end
			default: begin
				mx = a_q;
				my = b_q;
			end
		endcase
		ux = abs_acc(mx);
		uy = abs_acc(my);
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			hh_s1  <= ux[ACC_W-1:FRAC_BITS] * uy[ACC_W-1:FRAC_BITS];
			hl_s1  <= ux[ACC_W-1:FRAC_BITS] * uy[FRAC_BITS-1:0];
			lh_s1  <= ux[FRAC_BITS-1:0] * uy[ACC_W-1:FRAC_BITS];
			ll_s1  <= ux[FRAC_BITS-1:0] * uy[FRAC_BITS-1:0];
			neg_s1 <= mx[ACC_W-1] ^ my[ACC_W-1];
			sel_s1 <= cmd.sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	// stage 2: sum partial products, truncate toward zero, saturate
	logic                    hh_ovf;
	logic [SUM_W-1:0]        mag;
	logic signed [ACC_W-1:0] prod;

	always_comb begin
		hh_ovf = |hh_s1[PP_W-1:ACC_W-1-FRAC_BITS];
		mag = SUM_W'({hh_s1[ACC_W-2-FRAC_BITS:0], {FRAC_BITS{1'b0}}})
			+ SUM_W'(hl_s1) + SUM_W'(lh_s1) + SUM_W'(ll_s1[PP_W-1:FRAC_BITS]);
		if (neg_s1) begin
			if (hh_ovf || mag > (SUM_W'(1) << (ACC_W - 1)))
				prod = ACC_MIN;
			else
				prod = -$signed(mag[ACC_W-1:0]);
		end else begin
			if (hh_ovf || mag > SUM_W'(ACC_MAX))
				prod = ACC_MAX;
			else
				prod = $signed(mag[ACC_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			case (sel_s1)
				SEL_AA:  aa_q <= prod;
				SEL_BB:  bb_q <= prod;
				default: ab_q <= prod;
			endcase
		end
	end

	// next iterate from the three products
	logic signed [SUM_W-1:0] sum_a, sum_b;

	always_comb begin
		sum_a = SUM_W'(aa_q) - SUM_W'(bb_q) - SUM_W'(re_q);
		sum_b = $signed({ab_q[ACC_W-1], ab_q, 1'b0}) - SUM_W'(im_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			re_q <= point_re;
			im_q <= point_im;
			a_q  <= ACC_W'(point_re);
			b_q  <= ACC_W'(point_im);
		end else if (cmd.update) begin
			a_q <= sat_acc(sum_a);
			b_q <= sat_acc(sum_b);
		end
	end

	assign sts.above_thr = a_q > THRESHOLD;

endmodule

// ===== rtl/mbe_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer for the iteration loop, iteration counter and result register
module mbe_ctrl
	import mbe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ITER_W-1:0] iteration_limit,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [ITER_W-1:0] iteration_count,
	output logic              escaped,
	output mbe_cmd_t          cmd,
	input  mbe_sts_t          sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MBB   = 3'd2;
	localparam logic [2:0] ST_MAB   = 3'd3;
	localparam logic [2:0] ST_MFIN  = 3'd4;
	localparam logic [2:0] ST_UPD   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [ITER_W-1:0] iter_q;
	logic [ITER_W-1:0] res_cnt_q;
	logic              res_esc_q;
	logic [ITER_W-1:0] iter_nxt;
	logic              out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign iter_nxt = iter_q + ITER_W'(1);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd = '0;
		cmd.sel = SEL_AA;
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid;
			ST_CHECK: cmd.issue = 1'b1;
			ST_MBB: begin
				cmd.issue = 1'b1;
				cmd.sel   = SEL_BB;
			end
			ST_MAB: begin
				cmd.issue = 1'b1;
				cmd.sel   = SEL_AB;
			end
			ST_UPD:   cmd.update = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iter_q    <= '0;
			res_cnt_q <= '0;
			res_esc_q <= 1'b0;
			out_valid <= 1'b0;
			iteration_count <= '0;
			escaped   <= 1'b0;
		end else begin
			// in the done state a taken result is replaced below
			if (out_valid && out_ready && state_q != ST_DONE)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						iter_q <= '0;
						if (iteration_limit == '0) begin
							res_cnt_q <= '0;
							res_esc_q <= 1'b0;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// speculative a*a issue is harmless when the loop ends here
					if (sts.above_thr) begin
						res_cnt_q <= iter_q;
						res_esc_q <= 1'b1;
						state_q   <= ST_DONE;
					end else if (iter_nxt == iteration_limit) begin
						res_cnt_q <= iteration_limit;
						res_esc_q <= 1'b0;
						state_q   <= ST_DONE;
					end else begin
						iter_q  <= iter_nxt;
						state_q <= ST_MBB;
					end
				end
				ST_MBB:  state_q <= ST_MAB;
				ST_MAB:  state_q <= ST_MFIN;
				ST_MFIN: state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_CHECK;
				ST_DONE: begin
					if (out_free) begin
						out_valid       <= 1'b1;
						iteration_count <= res_cnt_q;
						escaped         <= res_esc_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/mandelbrot_escape_iteration_top.sv =====
`timescale 1ns / 1ps
// Escape-time iteration for one complex point per transfer.
// s_axis carries the point (Q8.24 real and imaginary parts); m_axis returns
// the iteration count, with the escaped flag on tuser. cfg sets the
// iteration limit (reset value 256) and is always ready; write it only
// while the block is idle.
// One point is worked on at a time. After the input transfer the block
// checks the start value, then for each further iteration one shared split
// multiplier forms a*a, b*b and a*b in turn, each through the partial-product
// registers and then its own product register, overlapped, and an update
// state applies the update.
// A finished result sits in the output register until taken; s_axis_tready
// rises again as soon as the result has been moved there, so the next
// point can be computed while the receiver stalls. A second result then
// waits inside until the first transfer completes.
// Reset clears the sequencer and the output valid and restores the limit.
module mandelbrot_escape_iteration_top
	import mbe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [2*COORD_W-1:0]   s_axis_tdata,   // point_re, point_im
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [8*OUT_BYTES-1:0] m_axis_tdata,   // iteration_count
	output logic                   m_axis_tuser,   // escaped
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ITER_W-1:0]      cfg_data        // iteration_limit
);

	logic [ITER_W-1:0] iteration_limit_q;
	logic [ITER_W-1:0] iteration_count;
	mbe_cmd_t          cmd;
	mbe_sts_t          sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iteration_limit_q <= ITER_W'(256);
		end else if (cfg_valid) begin
			iteration_limit_q <= cfg_data;
		end
	end

	mbe_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.iteration_limit (iteration_limit_q),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.iteration_count (iteration_count),
		.escaped         (m_axis_tuser),
		.cmd             (cmd),
		.sts             (sts)
	);

	mbe_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.point_re (s_axis_tdata[COORD_W-1:0]),
		.point_im (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign m_axis_tdata = (8*OUT_BYTES)'(iteration_count);

endmodule

// ===== test/mbe_escape_checker.sv =====
`timescale 1ns / 1ps
// watches the point, result and limit channels and scores every escape result
module mbe_escape_checker
	import mbe_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [2*COORD_W-1:0]   s_axis_tdata,   // point_re, point_im
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [8*OUT_BYTES-1:0] m_axis_tdata,   // iteration_count
	input  logic                   m_axis_tuser,   // escaped
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [ITER_W-1:0]      cfg_data,       // iteration_limit
	output int                     fail_count,
	output int                     results_pending
);

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [ACC_W+3:0] wide_t;

	typedef struct packed {
		logic [ITER_W-1:0] count;
		logic              escaped;
	} escape_result_t;

	localparam logic signed [2*ACC_W-1:0] FRAC_ONE = 1 <<< FRAC_BITS;

	logic [ITER_W-1:0] iter_limit;
	escape_result_t    expected_escapes[$];
	int                result_index;

	function automatic acc_t clamp_q24(input wide_t v);
		if (v > ACC_MAX)
			return ACC_MAX;
		if (v < ACC_MIN)
			return ACC_MIN;
		return v[ACC_W-1:0];
	endfunction

	// q24.24 product, truncated toward zero, then clamped
	function automatic acc_t mul_q24(input acc_t x, input acc_t y);
		logic signed [2*ACC_W-1:0] prod;
		logic signed [2*ACC_W-1:0] quo;
		prod = x * y;
		quo = prod / FRAC_ONE;
		if (quo > ACC_MAX)
			return ACC_MAX;
		if (quo < ACC_MIN)
			return ACC_MIN;
		return quo[ACC_W-1:0];
	endfunction

	// iterate z = z*z - p from z = p until the real part passes the threshold
	function automatic escape_result_t predict_escape(input logic [2*COORD_W-1:0] point,
			input logic [ITER_W-1:0] lim);
		acc_t           re;
		acc_t           im;
		acc_t           a;
		acc_t           b;
		acc_t           next_a;
		acc_t           t;
		wide_t          wide;
		escape_result_t r;
		re = $signed(point[COORD_W-1:0]);
		im = $signed(point[2*COORD_W-1:COORD_W]);
		a = re;
		b = im;
		r.count = lim;
		r.escaped = 1'b0;
		for (int i = 0; i < lim; i++) begin
			if (i != 0) begin
				wide = mul_q24(a, a) - mul_q24(b, b) - re;
				next_a = clamp_q24(wide);
				t = mul_q24(a, b);
				wide = t + t - im;
				b = clamp_q24(wide);
				a = next_a;
			end
			if (a > THRESHOLD) begin
				r.count = ITER_W'(i);
				r.escaped = 1'b1;
				return r;
			end
		end
		return r;
	endfunction

	task automatic note_failure(input escape_result_t want, input escape_result_t got,
			input bit unexpected);
		fail_count <= fail_count + 1;
		if (fail_count < 10) begin
			if (unexpected)
				$display("%0t: result %0d with nothing expected: count %0d escaped %0d",
					$realtime, result_index, got.count, got.escaped);
			else
				$display("%0t: result %0d: count exp %0d got %0d, escaped exp %0d got %0d",
					$realtime, result_index, want.count, got.count, want.escaped,
					got.escaped);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		escape_result_t want;
		escape_result_t got;
		if (!arst_n) begin
			iter_limit = 16'd256;
			expected_escapes.delete();
			result_index = 0;
			fail_count <= 0;
			results_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				iter_limit = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_escapes.push_back(predict_escape(s_axis_tdata, iter_limit));
			if (m_axis_tvalid && m_axis_tready) begin
				got.count = m_axis_tdata[ITER_W-1:0];
				got.escaped = m_axis_tuser;
				if (expected_escapes.size() == 0) begin
					want = '0;
					note_failure(want, got, 1'b1);
				end else begin
					want = expected_escapes.pop_front();
					if (got.count !== want.count || got.escaped !== want.escaped)
						note_failure(want, got, 1'b0);
				end
				result_index++;
			end
			results_pending <= expected_escapes.size();
		end
	end

endmodule

// ===== test/mandelbrot_escape_iteration_top_tb.sv =====
`timescale 1ns / 1ps
// stimulus, flow control and verdict for the escape-time block
module mandelbrot_escape_iteration_top_tb;
	import mbe_pkg::*;

	localparam int          HOLD_CYCLES   = 500;
	localparam int          SETTLE_CYCLES = 50;
	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int          SPAN          = 41943040;  // 2.5 in q8.24

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [2*COORD_W-1:0]   s_axis_tdata = '0;    // point_re, point_im
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [8*OUT_BYTES-1:0] m_axis_tdata;         // iteration_count
	logic                   m_axis_tuser;         // escaped
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [ITER_W-1:0]      cfg_data = '0;        // iteration_limit

	int          fail_count;
	int          results_pending;
	int unsigned cycle_count = 0;
	bit          hold_req = 1'b0;
	bit          tx_steady = 1'b0;
	bit          rx_steady = 1'b0;

	mandelbrot_escape_iteration_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	mbe_escape_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// sender gap, with runs of back-to-back points now and then
	function automatic int draw_gap();
		if ($urandom_range(0, 15) == 0)
			tx_steady = !tx_steady;
		return tx_steady ? 0 : $urandom_range(0, 19);
	endfunction

	// mostly near the set, sometimes anywhere in q8.24
	function automatic logic [COORD_W-1:0] draw_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return COORD_W'($urandom_range(0, 2 * SPAN)) - COORD_W'(SPAN);
	endfunction

	// real part 40..127 with small imaginary part escapes at the first update
	function automatic logic [COORD_W-1:0] fast_re();
		return {8'($urandom_range(40, 127)), 24'($urandom)};
	endfunction

	function automatic logic [COORD_W-1:0] fast_im();
		return COORD_W'($urandom_range(0, 16 << FRAC_BITS)) - COORD_W'(8 << FRAC_BITS);
	endfunction

	task automatic send_point(input logic [COORD_W-1:0] re, input logic [COORD_W-1:0] im,
			input int gap);
		bit ok;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {im, re};
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [ITER_W-1:0] lim);
		bit ok;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= lim;
		do begin
			@(negedge clk);
			ok = cfg_ready;
			@(posedge clk);
		end while (!ok);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		bit got;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				rx_steady = !rx_steady;
			stall = rx_steady ? 0 : $urandom_range(0, 19);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(negedge clk);
				got = m_axis_tvalid;
				@(posedge clk);
			end while (!got);
		end
	end

	initial begin
		logic [ITER_W-1:0] phase_limits[8];
		phase_limits = '{16'd3, 16'd8, 16'd64, 16'd24, 16'd40, 16'd12, 16'd48, 16'd32};
		@(posedge arst_n);
		@(posedge clk);

		// reset limit of 256: corners, fixed points and near-threshold cases
		send_point(32'h0000_0000, 32'h0000_0000, draw_gap());
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, draw_gap());
		send_point(32'h8000_0000, 32'h8000_0000, draw_gap());
		send_point(32'h7FFF_FFFF, 32'h8000_0000, draw_gap());
		send_point(32'h8000_0000, 32'h7FFF_FFFF, draw_gap());
		send_point(32'h7FFF_FFFF, 32'h0000_0000, draw_gap());
		send_point(32'h8000_0000, 32'h0000_0000, draw_gap());
		send_point(32'h0000_0000, 32'h7FFF_FFFF, draw_gap());
		send_point(32'h0000_0000, 32'h8000_0000, draw_gap());
		send_point(32'h0100_0000, 32'h0000_0000, draw_gap());
		send_point(32'hFF00_0000, 32'h0000_0000, draw_gap());
		send_point(32'h0200_0000, 32'h0000_0000, draw_gap());
		send_point(32'hFE00_0000, 32'h0000_0000, draw_gap());
		send_point(32'h0000_0000, 32'h0100_0000, draw_gap());
		send_point(32'h0000_0001, 32'hFFFF_FFFF, draw_gap());
		send_point(32'hFFFF_FFFF, 32'h0000_0001, draw_gap());
		send_point(32'h2200_0000, 32'h0000_0000, draw_gap());
		send_point(32'h2000_0000, 32'h0000_0000, draw_gap());
		send_point(32'h0040_0000, 32'h0040_0000, draw_gap());
		send_point(32'h5555_5555, 32'hAAAA_AAAA, draw_gap());

		// zero limit, then limit 1 (no update) and limit 2, the smallest that runs an update
		for (int lim = 0; lim <= 2; lim++) begin
			set_limit(ITER_W'(lim));
			repeat (10) send_point(draw_coord(), draw_coord(), draw_gap());
		end

		// largest limit only with points that leave quickly
		set_limit({ITER_W{1'b1}});
		repeat (8) send_point(fast_re(), fast_im(), draw_gap());

		for (int p = 0; p < 8; p++) begin
			if (p == 7)
				phase_limits[p] = ITER_W'($urandom_range(3, 64));
			set_limit(phase_limits[p]);
			if (p == 2) begin
				// stall the result side long enough for the input to back up
				hold_req = 1'b1;
				repeat (12) send_point(fast_re(), fast_im(), 0);
			end
			repeat (45) send_point(draw_coord(), draw_coord(), draw_gap());
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && results_pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
